// ===== hw/rtl/tbk_pkg.sv =====
// Timer bank package: command/result codes, transaction payload types, slot record.
// No dependencies; used by the interfaces, the top level, the checker and the testbench.
`timescale 1ns / 1ps

package tbk_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int MAX_RESULTS    = 16;

    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_ADD    = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;
    localparam logic [1:0] KIND_CLEAR  = 2'd3;

    localparam logic [2:0] RES_ADDED     = 3'd0;
    localparam logic [2:0] RES_FULL      = 3'd1;
    localparam logic [2:0] RES_REMOVED   = 3'd2;
    localparam logic [2:0] RES_NOT_FOUND = 3'd3;
    localparam logic [2:0] RES_CLEARED   = 3'd4;
    localparam logic [2:0] RES_FIRED     = 3'd5;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] tick_delta;
        logic [31:0] period;
        logic        repeat_req;
        logic [15:0] event_code;
        logic [15:0] target_id;
        logic [15:0] timer_id;
    } cmd_item_t;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [15:0] result_id;
        logic [15:0] fired_event;
        logic [15:0] fired_target;
        logic        last;
    } rsp_item_t;

    typedef struct packed {
        logic [31:0] remaining;
        logic [31:0] period;
        logic        repeat_en;
        logic [15:0] event_code;
        logic [15:0] target_id;
        logic [15:0] ident;
    } slot_t;

endpackage

// ===== hw/rtl/tbk_cmd_if.sv =====
// Command channel interface: valid/ready handshake with a command payload.
// Depends on tbk_pkg.
`timescale 1ns / 1ps

interface tbk_cmd_if;
    logic                valid;
    logic                ready;
    tbk_pkg::cmd_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/tbk_rsp_if.sv =====
// Result channel interface: valid/ready handshake with a result payload.
// Depends on tbk_pkg.
`timescale 1ns / 1ps

interface tbk_rsp_if;
    logic                valid;
    logic                ready;
    tbk_pkg::rsp_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/timer_bank_one_shot_periodic.sv =====
// A tick, add or remove walks every slot, one slot per cycle through the slot memory
// read port unless a tick stalls while the result register is held by the sink; a clear
// skips the walk. A new command is accepted only in idle, once the previous command's
// final result has been loaded into the result register. Fired timers emerge during the walk.
// Reset: all slots free, next id zero, no result pending; slot memory is not cleared.
// Depends on tbk_pkg, tbk_cmd_if, tbk_rsp_if.
`timescale 1ns / 1ps

module timer_bank_one_shot_periodic #(
    parameter int NUM_TIMERS = tbk_pkg::NUM_TIMERS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    tbk_cmd_if.sink   cmd,
    tbk_rsp_if.source rsp
);

    localparam int IdxW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CntW = $clog2(NUM_TIMERS + 1);
    localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_TIMERS - 1);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_WALK   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t                  state_reg, state_next;
    tbk_pkg::cmd_item_t      cmd_reg, cmd_next;
    logic [IdxW-1:0]         eval_idx_reg, eval_idx_next;
    logic [NUM_TIMERS-1:0]   valid_reg, valid_next;
    logic [15:0]             next_ident_reg, next_ident_next;
    logic                    hit_reg, hit_next;
    logic [IdxW-1:0]         hit_idx_reg, hit_idx_next;
    logic                    free_reg, free_next;
    logic [IdxW-1:0]         free_idx_reg, free_idx_next;
    logic [CntW-1:0]         fire_cnt_reg, fire_cnt_next;
    logic                    pend_valid_reg, pend_valid_next;
    logic [CntW-1:0]         pend_idx_reg, pend_idx_next;
    logic [15:0]             pend_id_reg, pend_id_next;
    logic [15:0]             pend_event_reg, pend_event_next;
    logic [15:0]             pend_target_reg, pend_target_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    tbk_pkg::rsp_item_t      rsp_data_reg, rsp_data_next;

    tbk_pkg::slot_t          slot_mem [NUM_TIMERS];
    tbk_pkg::slot_t          rd_data_reg;
    logic [IdxW-1:0]         rd_idx;
    logic                    mem_we;
    logic [IdxW-1:0]         mem_waddr;
    tbk_pkg::slot_t          mem_wdata;

    logic                    cur_valid;
    logic                    due;
    logic                    pend_emit_ok;
    logic                    pend_last;
    logic                    out_free;
    logic                    stall;
    logic                    emit;
    tbk_pkg::rsp_item_t      emit_data;
    logic [IdxW-1:0]         add_idx;

    assign cur_valid    = valid_reg[eval_idx_reg];
    assign due          = (rd_data_reg.remaining <= cmd_reg.tick_delta);
    assign pend_emit_ok = pend_valid_reg && (32'(pend_idx_reg) < 32'(tbk_pkg::MAX_RESULTS));
    assign pend_last    = (32'(pend_idx_reg) == 32'(tbk_pkg::MAX_RESULTS - 1));
    assign out_free     = !rsp_valid_reg || rsp.ready;
    assign add_idx      = hit_reg ? hit_idx_reg : free_idx_reg;

    assign cmd.ready = (state_reg == ST_IDLE);
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        eval_idx_next    = eval_idx_reg;
        valid_next       = valid_reg;
        next_ident_next  = next_ident_reg;
        hit_next         = hit_reg;
        hit_idx_next     = hit_idx_reg;
        free_next        = free_reg;
        free_idx_next    = free_idx_reg;
        fire_cnt_next    = fire_cnt_reg;
        pend_valid_next  = pend_valid_reg;
        pend_idx_next    = pend_idx_reg;
        pend_id_next     = pend_id_reg;
        pend_event_next  = pend_event_reg;
        pend_target_next = pend_target_reg;
        rd_idx           = '0;
        mem_we           = 1'b0;
        mem_waddr        = eval_idx_reg;
        mem_wdata        = rd_data_reg;
        stall            = 1'b0;
        emit             = 1'b0;
        emit_data        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    cmd_next        = cmd.data;
                    eval_idx_next   = '0;
                    hit_next        = 1'b0;
                    free_next       = 1'b0;
                    fire_cnt_next   = '0;
                    pend_valid_next = 1'b0;
                    if (cmd.data.kind == tbk_pkg::KIND_CLEAR)
                    begin
                        valid_next = '0;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_WALK;
                    end
                end
            end

            ST_WALK:
            begin
                case (cmd_reg.kind)
                    tbk_pkg::KIND_TICK:
                    begin
                        if (cur_valid)
                        begin
                            if (due)
                            begin
                                if (pend_emit_ok)
                                begin
                                    if (out_free)
                                    begin
                                        emit                   = 1'b1;
                                        emit_data.result_kind  = tbk_pkg::RES_FIRED;
                                        emit_data.result_id    = pend_id_reg;
                                        emit_data.fired_event  = pend_event_reg;
                                        emit_data.fired_target = pend_target_reg;
                                        emit_data.last         = pend_last;
                                    end
                                    else
                                    begin
                                        stall = 1'b1;
                                    end
                                end
                                if (!stall)
                                begin
                                    pend_valid_next  = 1'b1;
                                    pend_idx_next    = fire_cnt_reg;
                                    pend_id_next     = rd_data_reg.ident;
                                    pend_event_next  = rd_data_reg.event_code;
                                    pend_target_next = rd_data_reg.target_id;
                                    fire_cnt_next    = fire_cnt_reg + 1'b1;
                                    if (rd_data_reg.repeat_en)
                                    begin
                                        mem_we              = 1'b1;
                                        mem_wdata.remaining = rd_data_reg.period;
                                    end
                                    else
                                    begin
                                        valid_next[eval_idx_reg] = 1'b0;
                                    end
                                end
                            end
                            else
                            begin
                                mem_we              = 1'b1;
                                mem_wdata.remaining = rd_data_reg.remaining
                                                      - cmd_reg.tick_delta;
                            end
                        end
                    end

                    tbk_pkg::KIND_ADD:
                    begin
                        if (cur_valid && !hit_reg && rd_data_reg.ident == next_ident_reg)
                        begin
                            hit_next     = 1'b1;
                            hit_idx_next = eval_idx_reg;
                        end
                        if (!cur_valid && !free_reg)
                        begin
                            free_next     = 1'b1;
                            free_idx_next = eval_idx_reg;
                        end
                    end

                    tbk_pkg::KIND_REMOVE:
                    begin
                        if (cur_valid && !hit_reg && rd_data_reg.ident == cmd_reg.timer_id)
                        begin
                            hit_next                 = 1'b1;
                            valid_next[eval_idx_reg] = 1'b0;
                        end
                    end

                    default:
                    begin
                    end
                endcase

                if (stall)
                begin
                    rd_idx = eval_idx_reg;
                end
                else
                begin
                    rd_idx = (eval_idx_reg == LastIdx) ? '0 : eval_idx_reg + 1'b1;
                    if (eval_idx_reg == LastIdx)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        eval_idx_next = eval_idx_reg + 1'b1;
                    end
                end
            end

            ST_FINISH:
            begin
                case (cmd_reg.kind)
                    tbk_pkg::KIND_TICK:
                    begin
                        if (pend_emit_ok)
                        begin
                            if (out_free)
                            begin
                                emit                   = 1'b1;
                                emit_data.result_kind  = tbk_pkg::RES_FIRED;
                                emit_data.result_id    = pend_id_reg;
                                emit_data.fired_event  = pend_event_reg;
                                emit_data.fired_target = pend_target_reg;
                                emit_data.last         = 1'b1;
                                state_next             = ST_IDLE;
                            end
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end

                    tbk_pkg::KIND_ADD:
                    begin
                        if (out_free)
                        begin
                            emit           = 1'b1;
                            emit_data.last = 1'b1;
                            state_next     = ST_IDLE;
                            if (hit_reg || free_reg)
                            begin
                                mem_we               = 1'b1;
                                mem_waddr            = add_idx;
                                mem_wdata.remaining  = cmd_reg.period;
                                mem_wdata.period     = cmd_reg.period;
                                mem_wdata.repeat_en  = cmd_reg.repeat_req;
                                mem_wdata.event_code = cmd_reg.event_code;
                                mem_wdata.target_id  = cmd_reg.target_id;
                                mem_wdata.ident      = next_ident_reg;
                                valid_next[add_idx]  = 1'b1;
                                emit_data.result_kind = tbk_pkg::RES_ADDED;
                                emit_data.result_id   = next_ident_reg;
                                next_ident_next       = next_ident_reg + 16'd1;
                            end
                            else
                            begin
                                emit_data.result_kind = tbk_pkg::RES_FULL;
                            end
                        end
                    end

                    tbk_pkg::KIND_REMOVE:
                    begin
                        if (out_free)
                        begin
                            emit                  = 1'b1;
                            emit_data.result_kind = hit_reg ? tbk_pkg::RES_REMOVED
                                                            : tbk_pkg::RES_NOT_FOUND;
                            emit_data.result_id   = cmd_reg.timer_id;
                            emit_data.last        = 1'b1;
                            state_next            = ST_IDLE;
                        end
                    end

                    default:
                    begin
                        if (out_free)
                        begin
                            emit                  = 1'b1;
                            emit_data.result_kind = tbk_pkg::RES_CLEARED;
                            emit_data.last        = 1'b1;
                            state_next            = ST_IDLE;
                        end
                    end
                endcase
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        rsp_valid_next = emit ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_reg);
        rsp_data_next  = emit ? emit_data : rsp_data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            eval_idx_reg   <= '0;
            valid_reg      <= '0;
            next_ident_reg <= '0;
            hit_reg        <= 1'b0;
            free_reg       <= 1'b0;
            fire_cnt_reg   <= '0;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            eval_idx_reg   <= eval_idx_next;
            valid_reg      <= valid_next;
            next_ident_reg <= next_ident_next;
            hit_reg        <= hit_next;
            free_reg       <= free_next;
            fire_cnt_reg   <= fire_cnt_next;
            pend_valid_reg <= pend_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        hit_idx_reg     <= hit_idx_next;
        free_idx_reg    <= free_idx_next;
        pend_idx_reg    <= pend_idx_next;
        pend_id_reg     <= pend_id_next;
        pend_event_reg  <= pend_event_next;
        pend_target_reg <= pend_target_next;
        rsp_data_reg    <= rsp_data_next;
    end

    // slot memory: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= slot_mem[rd_idx];
    end

endmodule

// ===== hw/rtl/tbk_checker.sv =====
// Port-level checks for the timer bank, attached to the top level by bind.
// Depends on tbk_pkg and timer_bank_one_shot_periodic.
`timescale 1ns / 1ps

module tbk_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               cmd_valid,
    input logic               cmd_ready,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input tbk_pkg::rsp_item_t rsp_data
);

    // one command transaction at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("command accepted while previous one in flight");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("stalled result changed");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_data.result_kind <= tbk_pkg::RES_FIRED)
        else $error("result kind out of range");

    a_nonfire_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.result_kind != tbk_pkg::RES_FIRED |->
            rsp_data.fired_event == 16'd0 && rsp_data.fired_target == 16'd0
            && rsp_data.last)
        else $error("non-fire result with event fields or without last");

    a_fire_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ready && !rsp_data.last |-> !cmd_ready)
        else $error("fire burst ended without last");

endmodule

bind timer_bank_one_shot_periodic tbk_checker u_tbk_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

// ===== verif/tb.sv =====
// Testbench for timer_bank_one_shot_periodic: directed and random command streams
// with random valid/ready idling, results scored against an in-bench timer table.
// Depends on tbk_pkg, tbk_cmd_if, tbk_rsp_if and the timer_bank_one_shot_periodic RTL.
`timescale 1ns / 1ps

module tb;

    localparam int NT          = tbk_pkg::NUM_TIMERS_DEF;
    localparam int QUIET_LIMIT = 4000;
    localparam int TAIL        = NT + 22;
    localparam int RAND_ITEMS  = 234;
    localparam int CALM_ITEMS  = 60;
    localparam int MAX_REPORTS = 40;

    typedef struct {
        tbk_pkg::cmd_item_t cmd;
        bit                 drain;
    } stim_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    tbk_cmd_if cmd_ch();
    tbk_rsp_if rsp_ch();

    timer_bank_one_shot_periodic #(.NUM_TIMERS(NT)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    // timer table as the bench sees it
    bit          tm_live   [NT];
    logic [32:0] tm_left   [NT];
    logic [31:0] tm_period [NT];
    bit          tm_loop   [NT];
    logic [15:0] tm_event  [NT];
    logic [15:0] tm_target [NT];
    logic [15:0] tm_ident  [NT];
    logic [15:0] tm_next_id = '0;

    stim_t              cmd_pend_q[$];
    tbk_pkg::rsp_item_t rsp_due_q[$];
    stim_t              drv_cur;
    tbk_pkg::rsp_item_t want_rsp;

    bit idle_en    = 1'b0;
    bit gap_rolled = 1'b0;
    bit cmd_fire_q;
    int gap_left     = 0;
    int stall_left   = 0;
    int n_sent       = 0;
    int n_taken      = 0;
    int err_cnt      = 0;
    int quiet_cycles = 0;

    always #10 clk = ~clk;

    function automatic tbk_pkg::rsp_item_t mk_rsp(input logic [2:0] k,
                                                  input logic [15:0] id,
                                                  input logic [15:0] ev,
                                                  input logic [15:0] tg,
                                                  input logic last);
        tbk_pkg::rsp_item_t r;
        r.result_kind  = k;
        r.result_id    = id;
        r.fired_event  = ev;
        r.fired_target = tg;
        r.last         = last;
        return r;
    endfunction

    function automatic void bank_respond(input tbk_pkg::cmd_item_t c);
        int i;
        int hit;
        int fired[$];
        hit = -1;
        case (c.kind)
            tbk_pkg::KIND_TICK:
            begin
                for (i = 0; i < NT; i++)
                begin
                    if (tm_live[i])
                    begin
                        if (tm_left[i] <= {1'b0, c.tick_delta})
                        begin
                            fired.push_back(i);
                            if (tm_loop[i])
                                tm_left[i] = {1'b0, tm_period[i]};
                            else
                                tm_live[i] = 1'b0;
                        end
                        else
                            tm_left[i] = tm_left[i] - {1'b0, c.tick_delta};
                    end
                end
                for (i = 0; i < fired.size() && i < tbk_pkg::MAX_RESULTS; i++)
                    rsp_due_q.push_back(mk_rsp(tbk_pkg::RES_FIRED, tm_ident[fired[i]],
                        tm_event[fired[i]], tm_target[fired[i]],
                        (i == fired.size() - 1) || (i == tbk_pkg::MAX_RESULTS - 1)));
            end
            tbk_pkg::KIND_ADD:
            begin
                // a live timer already holding the next id is overwritten in place
                for (i = 0; i < NT && hit < 0; i++)
                    if (tm_live[i] && tm_ident[i] == tm_next_id)
                        hit = i;
                for (i = 0; i < NT && hit < 0; i++)
                    if (!tm_live[i])
                        hit = i;
                if (hit < 0)
                    rsp_due_q.push_back(mk_rsp(tbk_pkg::RES_FULL, '0, '0, '0, 1'b1));
                else
                begin
                    tm_live[hit]   = 1'b1;
                    tm_left[hit]   = {1'b0, c.period};
                    tm_period[hit] = c.period;
                    tm_loop[hit]   = c.repeat_req;
                    tm_event[hit]  = c.event_code;
                    tm_target[hit] = c.target_id;
                    tm_ident[hit]  = tm_next_id;
                    rsp_due_q.push_back(mk_rsp(tbk_pkg::RES_ADDED, tm_next_id, '0, '0,
                                               1'b1));
                    tm_next_id++;
                end
            end
            tbk_pkg::KIND_REMOVE:
            begin
                for (i = 0; i < NT && hit < 0; i++)
                    if (tm_live[i] && tm_ident[i] == c.timer_id)
                        hit = i;
                if (hit < 0)
                    rsp_due_q.push_back(mk_rsp(tbk_pkg::RES_NOT_FOUND, c.timer_id, '0, '0,
                                               1'b1));
                else
                begin
                    tm_live[hit] = 1'b0;
                    rsp_due_q.push_back(mk_rsp(tbk_pkg::RES_REMOVED, c.timer_id, '0, '0,
                                               1'b1));
                end
            end
            default:
            begin
                for (i = 0; i < NT; i++)
                    tm_live[i] = 1'b0;
                rsp_due_q.push_back(mk_rsp(tbk_pkg::RES_CLEARED, '0, '0, '0, 1'b1));
            end
        endcase
    endfunction

    function automatic tbk_pkg::cmd_item_t rand_cmd(input logic [1:0] k);
        tbk_pkg::cmd_item_t c;
        c.kind       = k;
        c.tick_delta = $urandom;
        c.period     = $urandom;
        c.repeat_req = 1'($urandom_range(0, 1));
        c.event_code = 16'($urandom_range(0, 16'hFFFF));
        c.target_id  = 16'($urandom_range(0, 16'hFFFF));
        c.timer_id   = 16'($urandom_range(0, 16'hFFFF));
        return c;
    endfunction

    task automatic queue_cmd(input tbk_pkg::cmd_item_t c, input bit drain);
        cmd_pend_q.push_back('{cmd: c, drain: drain});
        n_sent++;
    endtask

    task automatic check_field(input string f, input logic [15:0] w, input logic [15:0] g);
        if (g !== w)
        begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
                $display("%0t mismatch %s expected %h actual %h", $time, f, w, g);
        end
    endtask

    // command driver
    always @(negedge clk)
    begin
        if (rst_n && !(cmd_ch.valid && !cmd_fire_q))
        begin
            if (!gap_rolled)
            begin
                gap_rolled = 1'b1;
                if (idle_en && $urandom_range(0, 2) == 0)
                    gap_left = $urandom_range(1, 19);
            end
            if (gap_left > 0)
            begin
                gap_left--;
                cmd_ch.valid <= 1'b0;
            end
            else if (cmd_pend_q.size() == 0 ||
                     (cmd_pend_q[0].drain && rsp_due_q.size() != 0))
                cmd_ch.valid <= 1'b0;
            else
            begin
                drv_cur = cmd_pend_q.pop_front();
                cmd_ch.data  <= drv_cur.cmd;
                cmd_ch.valid <= 1'b1;
                gap_rolled    = 1'b0;
            end
        end
    end

    // result sink backpressure
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
        end
        else if (idle_en && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 18);
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= 1'b1;
    end

    // monitor, scoreboard and watchdog
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_fire_q <= 1'b0;
            quiet_cycles = 0;
        end
        else
        begin
            cmd_fire_q <= cmd_ch.valid && cmd_ch.ready;
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                bank_respond(cmd_ch.data);
                n_taken++;
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (rsp_due_q.size() == 0)
                begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display("%0t unexpected transaction: expected none actual %h",
                                 $time, rsp_ch.data);
                end
                else
                begin
                    want_rsp = rsp_due_q.pop_front();
                    check_field("result_kind", 16'(want_rsp.result_kind),
                                16'(rsp_ch.data.result_kind));
                    check_field("result_id", want_rsp.result_id, rsp_ch.data.result_id);
                    check_field("fired_event", want_rsp.fired_event,
                                rsp_ch.data.fired_event);
                    check_field("fired_target", want_rsp.fired_target,
                                rsp_ch.data.fired_target);
                    check_field("last", 16'(want_rsp.last), 16'(rsp_ch.data.last));
                end
            end
            if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("%0t watchdog: no transaction for %0d cycles", $time,
                             quiet_cycles);
                    $display("TB_ERROR");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        tbk_pkg::cmd_item_t c;
        int k;
        int j;
        int n;
        int sel;
        int pick;
        cmd_ch.valid = 1'b0;
        cmd_ch.data  = '0;
        rsp_ch.ready = 1'b0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // directed
        idle_en = 1'b1;
        c = rand_cmd(tbk_pkg::KIND_TICK);
        c.tick_delta = '0;
        queue_cmd(c, 1'b0);
        for (k = 0; k < NT; k++)
        begin
            c = rand_cmd(tbk_pkg::KIND_ADD);
            c.period     = (k == 0) ? 32'h0 : (k == NT - 1) ? 32'hFFFF_FFFF : k * 32'h1800;
            c.repeat_req = !k[0];
            if (k == 0)
            begin
                c.event_code = '1;
                c.target_id  = '1;
            end
            if (k == 1)
            begin
                c.event_code = '0;
                c.target_id  = '0;
            end
            queue_cmd(c, 1'b0);
        end
        queue_cmd(rand_cmd(tbk_pkg::KIND_ADD), 1'b0);
        c = rand_cmd(tbk_pkg::KIND_TICK);
        c.tick_delta = '0;
        queue_cmd(c, 1'b0);
        c = rand_cmd(tbk_pkg::KIND_TICK);
        c.tick_delta = '1;
        queue_cmd(c, 1'b1);
        c = rand_cmd(tbk_pkg::KIND_REMOVE);
        c.timer_id = 16'd2;
        queue_cmd(c, 1'b0);
        queue_cmd(c, 1'b0);
        c.timer_id = '1;
        queue_cmd(c, 1'b0);
        queue_cmd(rand_cmd(tbk_pkg::KIND_ADD), 1'b0);
        queue_cmd(rand_cmd(tbk_pkg::KIND_CLEAR), 1'b0);
        c = rand_cmd(tbk_pkg::KIND_TICK);
        c.tick_delta = '1;
        queue_cmd(c, 1'b0);

        // random
        while (n_taken != n_sent)
            @(posedge clk);
        idle_en = 1'b1;
        for (n = 0; n < RAND_ITEMS; n++)
        begin
            while (cmd_pend_q.size() > 1)
                @(posedge clk);
            if (n == RAND_ITEMS - CALM_ITEMS)
                idle_en = 1'b0;
            sel = $urandom_range(0, 99);
            if (sel < 38)
            begin
                c = rand_cmd(tbk_pkg::KIND_TICK);
                case ($urandom_range(0, 15))
                    0: c.tick_delta = '0;
                    1: c.tick_delta = '1;
                    2: c.tick_delta = $urandom;
                    default: c.tick_delta = $urandom_range(0, 32'h0002_0000);
                endcase
            end
            else if (sel < 75)
            begin
                c = rand_cmd(tbk_pkg::KIND_ADD);
                case ($urandom_range(0, 15))
                    0: c.period = '0;
                    1: c.period = '1;
                    2: c.period = $urandom;
                    default: c.period = $urandom_range(0, 32'h0004_0000);
                endcase
            end
            else if (sel < 96)
            begin
                c = rand_cmd(tbk_pkg::KIND_REMOVE);
                pick = -1;
                if ($urandom_range(0, 3) != 0)
                begin
                    k = $urandom_range(0, NT - 1);
                    for (j = 0; j < NT && pick < 0; j++)
                        if (tm_live[(k + j) % NT])
                            pick = (k + j) % NT;
                end
                if (pick >= 0)
                    c.timer_id = tm_ident[pick];
            end
            else
                c = rand_cmd(tbk_pkg::KIND_CLEAR);
            queue_cmd(c, $urandom_range(0, 24) == 0);
        end

        while (n_taken != n_sent)
            @(posedge clk);
        while (rsp_due_q.size() != 0)
            @(posedge clk);
        repeat (TAIL) @(posedge clk);
        if (err_cnt == 0 && rsp_due_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/tbk_pkg.sv
hw/rtl/tbk_cmd_if.sv
hw/rtl/tbk_rsp_if.sv
hw/rtl/timer_bank_one_shot_periodic.sv
hw/rtl/tbk_checker.sv
verif/tb.sv
